// File: design/drf_pkg.sv
// ============================================================================
// drf_pkg
// Shared types and constants of the delimited region finder: register map,
// marker pattern layout and output packing.
// ============================================================================
package drf_pkg;

    localparam int LEN_W        = 5;
    localparam int PAT_BYTES    = 16;
    localparam int OFFS_W       = 32;
    localparam int MAX_RESULTS  = 16;
    localparam int APB_ADDR_W   = 6;
    localparam int APB_DATA_W   = 64;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 2 * OFFS_W;

    typedef logic [LEN_W-1:0]           t_len;
    typedef logic [OFFS_W-1:0]          t_offs;
    typedef logic [PAT_BYTES-1:0][7:0]  t_pattern;

    // register indexes, byte address is 8 * index
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_START_LEN  = 3'd0;
    localparam t_reg_idx REG_START_LO   = 3'd1;
    localparam t_reg_idx REG_START_HI   = 3'd2;
    localparam t_reg_idx REG_END_LEN    = 3'd3;
    localparam t_reg_idx REG_END_LO     = 3'd4;
    localparam t_reg_idx REG_END_HI     = 3'd5;

endpackage

// File: design/delimited_region_finder_top.sv
// ============================================================================
// delimited_region_finder_top
// Finds regions of a byte stream framed by a start and an end marker.
//
// Usage: bytes enter on the s_axis channel, one per transaction, with tuser
// set on the first byte of a new stream (clears history, byte position and
// pending starts). Each start marker match queues the offset just past the
// marker; an end marker match pops every queued start at or before the end
// marker, oldest first, up to 16 per byte. Each popped start gives one
// m_axis transaction with the content start and end offsets; tlast marks the
// final region for that byte, tuser flags starts dropped on a full queue.
// Markers and lengths must be set over the APB port only while the block is
// idle; the block does not enforce this. A byte is matched in the cycle after
// it is taken; regions leave via the single output register. A byte is taken
// per cycle while it gives at most one region and m_axis does not stall; more
// regions hold the input, as the queue pops one entry per cycle while the
// output register is free. After reset the queue is empty, both marker lengths
// are 1 and the patterns are zero. When m_axis stalls, the output register
// holds its transaction and the input stalls once a new region is ready.
// ============================================================================
module delimited_region_finder_top #(
    parameter int MAX_MARKER_BYTES = 16,
    parameter int PENDING_DEPTH    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [drf_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // data_byte
    input  logic [0:0]                        s_axis_tuser,   // new_stream
    // regions out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [drf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // content_start, content_end
    output logic [0:0]                        m_axis_tuser,   // starts_dropped
    output logic                              m_axis_tlast,   // last_of_run
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [drf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [drf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [drf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import drf_pkg::*;

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int NEXT_IDX = (PENDING_DEPTH > 1) ? 1 : 0;

    // configuration registers
    t_len     r_start_len;
    t_len     r_end_len;
    t_pattern r_start_pat;
    t_pattern r_end_pat;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    // input stage
    logic                              r_a_valid;
    logic [MAX_MARKER_BYTES-1:0][7:0]  r_win;
    logic [MAX_MARKER_BYTES-1:0][7:0]  n_win;
    t_len                              r_fill;
    t_len                              n_fill;
    t_offs                             r_pos;
    t_offs                             n_pos;
    t_offs                             r_bytes;

    // pending queue, entry 0 is the oldest
    t_offs                 r_q [PENDING_DEPTH];
    t_offs                 n_q [PENDING_DEPTH];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      cnt_after;
    logic                  r_ovf;
    logic                  n_ovf;
    t_len                  r_nres;

    // output register
    logic                  r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic                  r_o_user;
    logic                  r_o_last;

    // matching and control
    t_len  slen;
    t_len  elen;
    logic  start_hit;
    logic  end_hit;
    logic  elig0;
    logic  elig1;
    logic  cand;
    logic  out_free;
    logic  pop;
    logic  last;
    logic  done;
    logic  push;
    logic  accept;
    t_offs end_off;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        unique case (reg_idx)
            REG_START_LEN: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, r_start_len};
            REG_START_LO:  prdata = r_start_pat[7:0];
            REG_START_HI:  prdata = r_start_pat[15:8];
            REG_END_LEN:   prdata = {{(APB_DATA_W-LEN_W){1'b0}}, r_end_len};
            REG_END_LO:    prdata = r_end_pat[7:0];
            REG_END_HI:    prdata = r_end_pat[15:8];
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_len <= LEN_W'(1);
            r_end_len   <= LEN_W'(1);
            r_start_pat <= '0;
            r_end_pat   <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_START_LEN: r_start_len       <= pwdata[LEN_W-1:0];
                REG_START_LO:  r_start_pat[7:0]  <= pwdata;
                REG_START_HI:  r_start_pat[15:8] <= pwdata;
                REG_END_LEN:   r_end_len         <= pwdata[LEN_W-1:0];
                REG_END_LO:    r_end_pat[7:0]    <= pwdata;
                REG_END_HI:    r_end_pat[15:8]   <= pwdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // marker matching on the registered window
    // ------------------------------------------------------------------------
    always_comb begin
        slen = r_start_len;
        if (slen == '0) begin
            slen = LEN_W'(1);
        end else if (slen > LEN_W'(MAX_MARKER_BYTES)) begin
            slen = LEN_W'(MAX_MARKER_BYTES);
        end
        elen = r_end_len;
        if (elen == '0) begin
            elen = LEN_W'(1);
        end else if (elen > LEN_W'(MAX_MARKER_BYTES)) begin
            elen = LEN_W'(MAX_MARKER_BYTES);
        end
    end

    always_comb begin
        t_len sidx;
        t_len eidx;
        start_hit = (r_fill >= slen);
        end_hit   = (r_fill >= elen);
        for (int k = 0; k < MAX_MARKER_BYTES; k++) begin
            sidx = slen - LEN_W'(1) - LEN_W'(k);
            eidx = elen - LEN_W'(1) - LEN_W'(k);
            if ((LEN_W'(k) < slen) && (r_win[k] != r_start_pat[sidx[3:0]])) begin
                start_hit = 1'b0;
            end
            if ((LEN_W'(k) < elen) && (r_win[k] != r_end_pat[eidx[3:0]])) begin
                end_hit = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // pop one pending start per cycle while the output is free, push at the end of the byte
    // ------------------------------------------------------------------------
    assign end_off  = r_pos - OFFS_W'(elen - LEN_W'(1));
    assign elig0    = (r_pos - r_q[0]) >= OFFS_W'(elen - LEN_W'(1));
    assign elig1    = (r_pos - r_q[NEXT_IDX]) >= OFFS_W'(elen - LEN_W'(1));
    assign out_free = !r_o_valid || m_axis_tready;
    assign cand     = r_a_valid && end_hit && (r_count != '0)
                      && (r_nres < LEN_W'(MAX_RESULTS)) && elig0;
    assign pop      = cand && out_free;
    assign last     = !((r_count > CNT_W'(1)) && (r_nres + LEN_W'(1) < LEN_W'(MAX_RESULTS))
                        && elig1);
    assign done     = r_a_valid && (cand ? (out_free && last) : 1'b1);
    assign cnt_after = r_count - CNT_W'(pop);
    assign push     = done && start_hit && (cnt_after < CNT_W'(PENDING_DEPTH));

    assign s_axis_tready = !r_a_valid || done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_count = cnt_after + CNT_W'(push);
        n_ovf   = r_ovf;
        if (done) begin
            if ((r_nres != '0) || pop) begin
                n_ovf = 1'b0;
            end
            if (start_hit && !push) begin
                n_ovf = 1'b1;
            end
        end
        if (accept && s_axis_tuser[0]) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < PENDING_DEPTH; i++) begin
            n_q[i] = r_q[i];
            if (pop && (i < PENDING_DEPTH - 1)) begin
                n_q[i] = r_q[(i < PENDING_DEPTH - 1) ? i + 1 : i];
            end
            if (push && (CNT_W'(i) == cnt_after)) begin
                n_q[i] = r_pos + OFFS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // ------------------------------------------------------------------------
    // input stage: window shift and byte position
    // ------------------------------------------------------------------------
    always_comb begin
        n_win  = s_axis_tuser[0] ? '0 : r_win;
        n_fill = s_axis_tuser[0] ? '0 : r_fill;
        n_pos  = s_axis_tuser[0] ? '0 : r_bytes;
        for (int k = MAX_MARKER_BYTES - 1; k > 0; k--) begin
            n_win[k] = n_win[k-1];
        end
        n_win[0] = s_axis_tdata;
        if (n_fill < LEN_W'(MAX_MARKER_BYTES)) begin
            n_fill = n_fill + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_win     <= '0;
            r_fill    <= '0;
            r_pos     <= '0;
            r_bytes   <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_nres    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (accept) begin
                r_a_valid <= 1'b1;
                r_win     <= n_win;
                r_fill    <= n_fill;
                r_pos     <= n_pos;
                r_bytes   <= n_pos + OFFS_W'(1);
            end else if (done) begin
                r_a_valid <= 1'b0;
            end
            if (done) begin
                r_nres <= '0;
            end else if (pop) begin
                r_nres <= r_nres + LEN_W'(1);
            end
            if (pop) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o_data <= {end_off, r_q[0]};
            r_o_user <= r_ovf;
            r_o_last <= last;
        end
    end

    assign m_axis_tvalid   = r_o_valid;
    assign m_axis_tdata    = r_o_data;
    assign m_axis_tuser[0] = r_o_user;
    assign m_axis_tlast    = r_o_last;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PENDING_DEPTH))
        else $error("pending count above queue depth");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= LEN_W'(MAX_RESULTS))
        else $error("too many regions for one byte");

    a_pop_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !m_axis_tready)
            |=> $stable(r_o_data) && $stable(r_o_user) && $stable(r_o_last))
        else $error("output transaction changed while stalled");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> s_axis_tready)
        else $error("input stalled with empty input stage");

endmodule
